>>> src/scope_pretrigger_capture_control_macros.svh
// Assertion macros for the capture control block.
`ifndef SCOPE_PRETRIGGER_CAPTURE_CONTROL_MACROS_SVH
`define SCOPE_PRETRIGGER_CAPTURE_CONTROL_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define SPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SPC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/spc_pkg.sv
package spc_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_CAPTURE_SIZE  = 2'd1,
    REG_TRIG_RISING   = 2'd2
  } reg_idx_e;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned PERIOD_US_W = 11;
  localparam int unsigned US_W        = 12;
  localparam int unsigned PROD_W      = 18;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned TICK_CAP_W  = 17;
  localparam logic [TICK_CAP_W-1:0] TICK_CAP = 17'h10000;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [PERIOD_US_W-1:0] PERIOD_RESET = 11'd1;
  localparam logic [CNT_W-1:0]       SIZE_RESET   = 16'd1024;

endpackage

>>> src/scope_pretrigger_capture_control.sv
// Channel  | Dir | Handshake                 | Payload
// s_axis   | in  | s_axis_tvalid/tready      | tuser: kind[1:0]; tdata: trigger_level[0]
// m_axis   | out | m_axis_tvalid/tready      | tdata: strobe, count, armed, triggered,
//          |     |                           |        offset, done
// cfg      | in  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One item per cycle while m_axis accepts; every item yields one result in the cycle after it is taken.
// The state update and result are computed in one pass: period multiply,
// counter compare and flag update ahead of the result register.
// s_axis_tready stays high unless the result register is full and m_axis stalls.
// Reset leaves the block idle with done set; state and configuration registers return to their defaults.
`include "scope_pretrigger_capture_control_macros.svh"

module scope_pretrigger_capture_control #(
  parameter int unsigned TICKS_PER_US  = 18,
  parameter int unsigned MAX_PERIOD_US = 2000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] trigger_level
  input  logic [spc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] sample_strobe, [16:1] sample_count, [17] armed, [18] triggered,
  // [34:19] trig_offset, [35] done_res
  output logic [spc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [spc_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned CntW = spc_pkg::CNT_W;

  logic [spc_pkg::PERIOD_US_W-1:0] period_us_q;
  logic [CntW-1:0]                 size_q;
  logic                            rising_q;

  logic [CntW-1:0] pc_q, pc_d;
  logic [CntW-1:0] samples_q, samples_d;
  logic [CntW-1:0] trig_cnt_q, trig_cnt_d;
  logic            counting_q, counting_d;
  logic            armed_q, armed_d;
  logic            triggered_q, triggered_d;
  logic [CntW-1:0] offset_q, offset_d;
  logic            done_q, done_d;
  logic            level_q, level_d;
  logic            strobe;

  logic                            out_valid_q;
  logic [spc_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic                            s_fire;
  logic                            in_level;
  spc_pkg::kind_e                  in_kind;
  logic [spc_pkg::US_W-1:0]        us_ext;
  logic [spc_pkg::US_W-1:0]        us_clamp;
  logic [spc_pkg::PROD_W-1:0]      prod;
  logic [spc_pkg::TICK_CAP_W-1:0]  ticks;
  logic [spc_pkg::TICK_CAP_W-1:0]  pc_next;
  logic                            edge_seen;
  logic [CntW-1:0]                 half_size;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_level      = s_axis_tdata[0];
  assign in_kind       = spc_pkg::kind_e'(s_axis_tuser);
  assign half_size     = size_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_us_q <= spc_pkg::PERIOD_RESET;
      size_q      <= spc_pkg::SIZE_RESET;
      rising_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spc_pkg::REG_SAMPLE_PERIOD: period_us_q <= cfg_data_i[spc_pkg::PERIOD_US_W-1:0];
        spc_pkg::REG_CAPTURE_SIZE:  size_q      <= cfg_data_i[CntW-1:0];
        spc_pkg::REG_TRIG_RISING:   rising_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    us_ext = spc_pkg::US_W'(period_us_q);
    if (us_ext == '0) begin
      us_clamp = spc_pkg::US_W'(1);
    end else if (us_ext > spc_pkg::US_W'(MAX_PERIOD_US)) begin
      us_clamp = spc_pkg::US_W'(MAX_PERIOD_US);
    end else begin
      us_clamp = us_ext;
    end
    prod = spc_pkg::PROD_W'(us_clamp) * spc_pkg::PROD_W'(TICKS_PER_US);
    if (prod > spc_pkg::PROD_W'(spc_pkg::TICK_CAP)) begin
      ticks = spc_pkg::TICK_CAP;
    end else begin
      ticks = prod[spc_pkg::TICK_CAP_W-1:0];
    end
  end

  always_comb begin
    pc_d        = pc_q;
    samples_d   = samples_q;
    trig_cnt_d  = trig_cnt_q;
    counting_d  = counting_q;
    armed_d     = armed_q;
    triggered_d = triggered_q;
    offset_d    = offset_q;
    done_d      = done_q;
    level_d     = level_q;
    strobe      = 1'b0;
    pc_next     = spc_pkg::TICK_CAP_W'(pc_q) + spc_pkg::TICK_CAP_W'(1);
    edge_seen   = rising_q ? (!level_q && in_level) : (level_q && !in_level);
    case (in_kind)
      spc_pkg::KIND_TICK: begin
        level_d = in_level;
        if (!done_q) begin
          if (armed_q && !triggered_q && edge_seen) begin
            offset_d    = trig_cnt_q;
            triggered_d = 1'b1;
            counting_d  = 1'b0;
          end
          if (pc_next >= ticks) begin
            pc_d      = '0;
            strobe    = 1'b1;
            samples_d = samples_q + CntW'(1);
            if (counting_d) begin
              trig_cnt_d = trig_cnt_q + CntW'(1);
            end
            if (!armed_q && samples_d >= half_size) begin
              armed_d  = 1'b1;
              offset_d = '0;
            end
            if (samples_d >= size_q) begin
              done_d     = 1'b1;
              counting_d = 1'b0;
            end
          end else begin
            pc_d = pc_next[CntW-1:0];
          end
        end
      end
      spc_pkg::KIND_START: begin
        pc_d        = '0;
        samples_d   = '0;
        trig_cnt_d  = '0;
        counting_d  = 1'b1;
        armed_d     = 1'b0;
        triggered_d = 1'b0;
        done_d      = 1'b0;
        if (half_size == '0) begin
          armed_d  = 1'b1;
          offset_d = '0;
        end
        if (size_q == '0) begin
          done_d     = 1'b1;
          counting_d = 1'b0;
        end
      end
      spc_pkg::KIND_STOP: begin
        if (!done_q) begin
          done_d     = 1'b1;
          counting_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      samples_q   <= '0;
      trig_cnt_q  <= '0;
      counting_q  <= 1'b0;
      armed_q     <= 1'b0;
      triggered_q <= 1'b0;
      offset_q    <= '0;
      done_q      <= 1'b1;
      level_q     <= 1'b0;
    end else if (s_fire) begin
      pc_q        <= pc_d;
      samples_q   <= samples_d;
      trig_cnt_q  <= trig_cnt_d;
      counting_q  <= counting_d;
      armed_q     <= armed_d;
      triggered_q <= triggered_d;
      offset_q    <= offset_d;
      done_q      <= done_d;
      level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {4'b0, done_d, offset_d, triggered_d, armed_d, samples_d, strobe};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SPC_ASSERT_SAME(a_trig_needs_arm, clk_i, rst_ni, triggered_q, armed_q)
  `SPC_ASSERT_SAME(a_done_stops_count, clk_i, rst_ni, done_q, !counting_q)
  `SPC_ASSERT_NEXT(a_start_clears, clk_i, rst_ni,
    s_fire && in_kind == spc_pkg::KIND_START, samples_q == '0 && pc_q == '0)
  `SPC_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, s_fire, out_valid_q)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned TICKS_US = 18;
  localparam int unsigned MAX_US = 2000;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 80;

  typedef struct packed {
    logic        strobe;
    logic [15:0] count;
    logic        armed;
    logic        triggered;
    logic [15:0] offset;
    logic        done;
  } capture_status_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [spc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = spc_pkg::KIND_TICK;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [spc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we_i = 1'b0;
  logic [1:0]                      cfg_idx_i = spc_pkg::REG_SAMPLE_PERIOD;
  logic [spc_pkg::CFG_W-1:0]       cfg_data_i = '0;

  scope_pretrigger_capture_control #(
    .TICKS_PER_US (TICKS_US),
    .MAX_PERIOD_US(MAX_US)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sequencer copy used for prediction
  logic [10:0] cfg_period_us = spc_pkg::PERIOD_RESET;
  logic [15:0] cfg_size = spc_pkg::SIZE_RESET;
  logic        cfg_rising = 1'b1;
  logic [15:0] seq_period_cnt = '0;
  logic [15:0] seq_samples = '0;
  logic [15:0] seq_trig_cnt = '0;
  logic        seq_trig_on = 1'b0;
  logic        seq_armed = 1'b0;
  logic        seq_triggered = 1'b0;
  logic [15:0] seq_offset = '0;
  logic        seq_done = 1'b1;
  logic        seq_level = 1'b0;

  capture_status_t pending_status_q[$];
  capture_status_t got_status;
  capture_status_t want_status;
  int unsigned     fail_count = 0;
  int unsigned     stall_cycles = 0;

  int unsigned burst_left = 0;
  int unsigned stall_pct = 30;
  bit          no_idle = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ready_run = 0;
  logic        ready_next = 1'b1;
  logic        drive_level = 1'b0;

  function automatic int unsigned ticks_per_sample();
    int unsigned us;
    int unsigned t;
    us = cfg_period_us;
    if (us < 1) us = 1;
    if (us > MAX_US) us = MAX_US;
    t = us * TICKS_US;
    if (t > 65536) t = 65536;
    return t;
  endfunction

  function automatic void arm_at_half();
    if (!seq_armed && seq_samples >= (cfg_size >> 1)) begin
      seq_armed = 1'b1;
      seq_offset = '0;
    end
  endfunction

  function automatic void end_capture();
    seq_done = 1'b1;
    seq_trig_on = 1'b0;
  endfunction

  function automatic capture_status_t advance_sequencer(logic [1:0] kind, logic lvl);
    capture_status_t res;
    logic            edge_seen;
    int unsigned     nxt;
    res.strobe = 1'b0;
    case (kind)
      spc_pkg::KIND_TICK: begin
        edge_seen = cfg_rising ? (!seq_level && lvl) : (seq_level && !lvl);
        seq_level = lvl;
        if (!seq_done) begin
          if (seq_armed && !seq_triggered && edge_seen) begin
            seq_offset = seq_trig_cnt;
            seq_triggered = 1'b1;
            seq_trig_on = 1'b0;
          end
          nxt = seq_period_cnt + 1;
          if (nxt >= ticks_per_sample()) begin
            seq_period_cnt = '0;
            res.strobe = 1'b1;
            seq_samples = seq_samples + 16'd1;
            if (seq_trig_on) seq_trig_cnt = seq_trig_cnt + 16'd1;
            arm_at_half();
            if (seq_samples >= cfg_size) end_capture();
          end else begin
            seq_period_cnt = nxt[15:0];
          end
        end
      end
      spc_pkg::KIND_START: begin
        seq_period_cnt = '0;
        seq_samples = '0;
        seq_trig_cnt = '0;
        seq_trig_on = 1'b1;
        seq_armed = 1'b0;
        seq_triggered = 1'b0;
        seq_done = 1'b0;
        arm_at_half();
        if (cfg_size == 16'd0) end_capture();
      end
      spc_pkg::KIND_STOP: begin
        if (!seq_done) end_capture();
      end
      default: begin
      end
    endcase
    res.count = seq_samples;
    res.armed = seq_armed;
    res.triggered = seq_triggered;
    res.offset = seq_offset;
    res.done = seq_done;
    return res;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic lvl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {{(spc_pkg::IN_TDATA_W-1){1'b0}}, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_status_q.push_back(advance_sequencer(kind, lvl));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [10:0] period, input logic [15:0] size,
                                input logic rising);
    wait_results_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= spc_pkg::REG_SAMPLE_PERIOD;
    cfg_data_i <= {5'b0, period};
    @(posedge clk_i);
    cfg_idx_i <= spc_pkg::REG_CAPTURE_SIZE;
    cfg_data_i <= size;
    @(posedge clk_i);
    cfg_idx_i <= spc_pkg::REG_TRIG_RISING;
    cfg_data_i <= {15'b0, rising};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_period_us = period;
    cfg_size = size;
    cfg_rising = rising;
  endtask

  task automatic test_idle_commands();
    send_item(KIND_UNUSED, 1'b1);
    send_item(spc_pkg::KIND_STOP, 1'b1);
    send_item(spc_pkg::KIND_TICK, 1'b1);
    send_item(spc_pkg::KIND_TICK, 1'b0);
    send_item(KIND_UNUSED, 1'b0);
  endtask

  task automatic test_capture_bounds();
    apply_settings(11'd0, 16'd0, 1'b1);
    send_item(spc_pkg::KIND_START, 1'b0);
    send_item(spc_pkg::KIND_TICK, 1'b1);
    apply_settings(11'd1, 16'd1, 1'b1);
    send_item(spc_pkg::KIND_START, 1'b0);
    send_item(spc_pkg::KIND_TICK, 1'b0);
    send_item(spc_pkg::KIND_TICK, 1'b1);
    send_item(spc_pkg::KIND_TICK, 1'b0);
    send_item(spc_pkg::KIND_TICK, 1'b1);
    send_item(spc_pkg::KIND_STOP, 1'b0);
    send_item(spc_pkg::KIND_STOP, 1'b0);
  endtask

  task automatic test_long_period_restart();
    apply_settings(11'd2047, 16'hFFFF, 1'b0);
    send_item(spc_pkg::KIND_START, 1'b1);
    send_item(spc_pkg::KIND_TICK, 1'b1);
    send_item(spc_pkg::KIND_TICK, 1'b0);
    send_item(KIND_UNUSED, 1'b1);
    send_item(spc_pkg::KIND_START, 1'b0);
    send_item(spc_pkg::KIND_START, 1'b1);
    send_item(spc_pkg::KIND_TICK, 1'b0);
    send_item(spc_pkg::KIND_STOP, 1'b1);
    send_item(spc_pkg::KIND_TICK, 1'b1);
  endtask

  task automatic run_capture(input int unsigned budget, inout int unsigned used);
    int unsigned tail;
    int unsigned r;
    tail = $urandom_range(2, 8);
    send_item(spc_pkg::KIND_START, drive_level);
    used++;
    while (used < budget && tail > 0) begin
      if (seq_done) tail--;
      if ($urandom_range(0, 5) == 0) drive_level = ~drive_level;
      r = $urandom_range(0, 199);
      if (r < 2) send_item(spc_pkg::KIND_STOP, drive_level);
      else if (r < 5) send_item(KIND_UNUSED, drive_level);
      else if (r < 7) send_item(spc_pkg::KIND_START, drive_level);
      else send_item(spc_pkg::KIND_TICK, drive_level);
      used++;
    end
  endtask

  task automatic test_random_captures();
    logic [10:0] periods[7] = '{11'd1, 11'd0, 11'd2, 11'd1, 11'd3, 11'd1, 11'd1};
    logic [15:0] sizes[7] = '{16'd4, 16'd3, 16'd5, 16'd1, 16'd2, 16'd7, 16'd0};
    logic        edges[7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int unsigned budgets[7] = '{150, 150, 150, 100, 130, 200, 20};
    int unsigned used;
    for (int p = 0; p < 7; p++) begin
      apply_settings(periods[p], sizes[p], edges[p]);
      no_idle = (p == 2);
      stall_pct = (p == 2) ? 0 : $urandom_range(10, 60);
      used = 0;
      while (used < budgets[p]) run_capture(budgets[p], used);
    end
    no_idle = 1'b0;
    stall_pct = 30;
  endtask

  task automatic test_output_backpressure();
    apply_settings(11'd1, 16'd6, 1'b1);
    no_idle = 1'b1;
    long_hold_req = 1'b1;
    send_item(spc_pkg::KIND_START, 1'b0);
    for (int i = 0; i < 40; i++) send_item(spc_pkg::KIND_TICK, i[2]);
    wait_results_drained();
    for (int i = 0; i < 20; i++) send_item(spc_pkg::KIND_TICK, i[1]);
    send_item(spc_pkg::KIND_STOP, 1'b0);
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (ready_run == 0) begin
        ready_next = ($urandom_range(0, 99) >= stall_pct);
        ready_run = $urandom_range(1, 6);
      end
      ready_run--;
      m_axis_tready <= ready_next;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status.strobe = m_axis_tdata[0];
      got_status.count = m_axis_tdata[16:1];
      got_status.armed = m_axis_tdata[17];
      got_status.triggered = m_axis_tdata[18];
      got_status.offset = m_axis_tdata[34:19];
      got_status.done = m_axis_tdata[35];
      if (pending_status_q.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want_status = pending_status_q.pop_front();
        check_field("sample_strobe", want_status.strobe, got_status.strobe);
        check_field("sample_count", want_status.count, got_status.count);
        check_field("armed", want_status.armed, got_status.armed);
        check_field("triggered", want_status.triggered, got_status.triggered);
        check_field("trig_offset", want_status.offset, got_status.offset);
        check_field("done_res", want_status.done, got_status.done);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_commands();
    test_capture_bounds();
    test_long_period_restart();
    test_output_backpressure();
    test_random_captures();
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
